// ----- hw/rtl/bfm_pkg.sv -----
package bfm_pkg;

    // Result lanes that one pixel can produce, in raster order of the results.
    localparam int LANES  = 4;
    localparam int LANE_A = 0;  // (r-1, c-1)
    localparam int LANE_B = 1;  // (r-1, last column) at a row end
    localparam int LANE_C = 2;  // (last row, c-1) in the last row
    localparam int LANE_D = 3;  // (last row, last column) at the frame end

    // Widths fixed by the stream format.
    localparam int PIXEL_W   = 8;
    localparam int SIZE_W    = 11;
    localparam int OUT_POS_W = 10;
    localparam int COLSUM_W  = 10;
    localparam int SUM_W     = 12;

    // Result queue between the filter pipeline and the output port.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // Reciprocals for the truncated mean: x/9 and x/3 as (x * K) >> 16.
    // Both are exact for x below 32768, far above the largest window sum.
    localparam int             RECIP_W     = 15;
    localparam int             RECIP_SHIFT = 16;
    localparam logic [14:0]    RECIP_9     = 15'd7282;
    localparam logic [14:0]    RECIP_3     = 15'd21846;

    // Number of in-bounds neighbours of a result pixel.
    typedef enum logic [1:0] {
        DIV_BY_4 = 2'd0,
        DIV_BY_6 = 2'd1,
        DIV_BY_9 = 2'd2
    } div_t;

    // One result word as it waits in the output queue.
    typedef struct packed {
        logic [PIXEL_W-1:0]   smoothed;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] column;
        logic                 last;
        logic                 eof;
    } result_t;

endpackage

// ----- hw/rtl/box_filter_3x3_edge_mean_unit.sv -----
// 3x3 box filter over a square 8-bit image streamed in raster order. Each result is the
// truncated mean of the in-bounds neighbours of a pixel in the original image (4 at corners,
// 6 on edges, 9 inside) and carries its row and column. Results trail the input by one row
// and one column; a row end below the first row releases two results, as does each later
// pixel of the last row, and the final pixel four; "last" marks the final result of each
// input word. The block takes one pixel per clock and delivers one result per clock while
// out_stall is low; the two previous rows sit in one line memory read and rewritten once
// per pixel, and a short result queue absorbs the extra results, so input is only stalled
// when that queue backs up. Writing image_size (clamped to 2..MAX_SIZE) restarts the frame
// at row 0, column 0; write it only while no results are outstanding.
module box_filter_3x3_edge_mean_unit #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bfm_pkg::SIZE_W-1:0]      image_size,
    // Pixel input channel.
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bfm_pkg::PIXEL_W-1:0]     pixel,
    // Result output channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bfm_pkg::PIXEL_W-1:0]     smoothed,
    output logic [bfm_pkg::OUT_POS_W-1:0]   out_row,
    output logic [bfm_pkg::OUT_POS_W-1:0]   out_column,
    output logic                            last,
    output logic                            end_of_frame
);

    localparam int PW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int LW = 2 * bfm_pkg::PIXEL_W;
    localparam int PRODUCT_W = bfm_pkg::SUM_W + bfm_pkg::RECIP_W;

    typedef logic [bfm_pkg::PIXEL_W-1:0]  pix_t;
    typedef logic [bfm_pkg::COLSUM_W-1:0] colsum_t;

    function automatic logic [bfm_pkg::OUT_POS_W-1:0] to_out_pos(input logic [PW-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[bfm_pkg::OUT_POS_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration and frame position
    // ------------------------------------------------------------------
    logic [bfm_pkg::SIZE_W-1:0] image_size_reg;
    logic [PW-1:0]              side_m1;
    logic [PW-1:0]              in_row_reg;
    logic [PW-1:0]              in_row_next;
    logic [PW-1:0]              in_column_reg;
    logic [PW-1:0]              in_column_next;
    logic                       cfg_write;
    logic                       accept;
    logic                       last_col;
    logic                       last_row;
    logic [bfm_pkg::LANES-1:0]  new_mask;
    logic [bfm_pkg::FIFO_CW-1:0] new_count;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Effective side length minus one, clamped to the supported range.
    always_comb
    begin
        priority if (image_size_reg < bfm_pkg::SIZE_W'(2))
        begin
            side_m1 = PW'(1);
        end
        else if (32'(image_size_reg) > MAX_SIZE)
        begin
            side_m1 = PW'(MAX_SIZE - 1);
        end
        else
        begin
            side_m1 = PW'(image_size_reg - bfm_pkg::SIZE_W'(1));
        end
    end

    assign last_col = (in_column_reg == side_m1);
    assign last_row = (in_row_reg == side_m1);

    // Which results the pixel at the current position releases.
    always_comb
    begin
        new_mask                 = '0;
        new_mask[bfm_pkg::LANE_A] = (in_row_reg != '0) && (in_column_reg != '0);
        new_mask[bfm_pkg::LANE_B] = (in_row_reg != '0) && last_col;
        new_mask[bfm_pkg::LANE_C] = last_row && (in_column_reg != '0);
        new_mask[bfm_pkg::LANE_D] = last_row && last_col;
        new_count = '0;
        for (int i = 0; i < bfm_pkg::LANES; i++)
        begin
            new_count = new_count + bfm_pkg::FIFO_CW'(new_mask[i]);
        end
    end

    always_comb
    begin
        if (last_col)
        begin
            in_column_next = '0;
            in_row_next    = last_row ? '0 : in_row_reg + PW'(1);
        end
        else
        begin
            in_column_next = in_column_reg + PW'(1);
            in_row_next    = in_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= bfm_pkg::SIZE_W'(8);
            in_row_reg     <= '0;
            in_column_reg  <= '0;
        end
        else if (cfg_write)
        begin
            image_size_reg <= image_size;
            in_row_reg     <= '0;
            in_column_reg  <= '0;
        end
        else if (accept)
        begin
            in_row_reg    <= in_row_next;
            in_column_reg <= in_column_next;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: results already promised to the queue are reserved.
    // ------------------------------------------------------------------
    logic [bfm_pkg::FIFO_CW-1:0] fifo_count;
    logic [bfm_pkg::FIFO_CW-1:0] pending_reg;
    logic [bfm_pkg::FIFO_CW-1:0] pending_next;
    logic [bfm_pkg::FIFO_CW:0]   committed;
    logic [bfm_pkg::FIFO_CW-1:0] s3_count;

    assign committed = (bfm_pkg::FIFO_CW + 1)'(fifo_count) + (bfm_pkg::FIFO_CW + 1)'(pending_reg)
                     + (bfm_pkg::FIFO_CW + 1)'(new_count);
    assign in_stall  = (committed > (bfm_pkg::FIFO_CW + 1)'(bfm_pkg::FIFO_DEPTH));
    assign accept    = in_valid && !in_stall;

    assign pending_next = pending_reg + (accept ? new_count : '0) - s3_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line memory read, holding {row r-2, row r-1} per column.
    // ------------------------------------------------------------------
    logic                      s1_valid_reg;
    pix_t                      s1_pixel_reg;
    logic [PW-1:0]             s1_column_reg;
    logic [bfm_pkg::LANES-1:0] s1_mask_reg;
    logic                      s1_row3_reg;
    logic                      s1_col3_reg;
    logic                      s1_eof_reg;
    logic [PW-1:0]             s1_rm1_reg;
    logic [PW-1:0]             s1_cm1_reg;
    logic [LW-1:0]             line_rd_data;
    logic [LW-1:0]             line_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg  <= pixel;
            s1_column_reg <= in_column_reg;
            s1_mask_reg   <= new_mask;
            s1_row3_reg   <= (32'(in_row_reg) >= 2);
            s1_col3_reg   <= (32'(in_column_reg) >= 2);
            s1_eof_reg    <= last_row && last_col;
            s1_rm1_reg    <= in_row_reg - PW'(1);
            s1_cm1_reg    <= in_column_reg - PW'(1);
        end
    end

    // The same column is written back in the cycle after it is read; consecutive
    // pixels never share a column, so no forwarding is needed.
    assign line_wr_data = {line_rd_data[bfm_pkg::PIXEL_W-1:0], s1_pixel_reg};

    bfm_line_store #(
        .DEPTH (MAX_SIZE),
        .AW    (PW),
        .WIDTH (LW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_column_reg),
        .rd_data (line_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_column_reg),
        .wr_data (line_wr_data)
    );

    // Window shift: cell [k][j] holds pixel (r-2+k, c-2+j).
    pix_t    window_reg  [3][3];
    pix_t    window_next [3][3];
    colsum_t colsum_full [3];
    colsum_t colsum_low  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            window_next[k][0] = window_reg[k][1];
            window_next[k][1] = window_reg[k][2];
        end
        window_next[0][2] = line_rd_data[LW-1:bfm_pkg::PIXEL_W];
        window_next[1][2] = line_rd_data[bfm_pkg::PIXEL_W-1:0];
        window_next[2][2] = s1_pixel_reg;
        for (int j = 0; j < 3; j++)
        begin
            colsum_low[j]  = colsum_t'(window_next[1][j]) + colsum_t'(window_next[2][j]);
            colsum_full[j] = colsum_low[j] + colsum_t'(window_next[0][j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    window_reg[k][j] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            window_reg <= window_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: column sums of the window, with and without the top row.
    // ------------------------------------------------------------------
    logic                      s2_valid_reg;
    logic [bfm_pkg::LANES-1:0] s2_mask_reg;
    logic                      s2_row3_reg;
    logic                      s2_col3_reg;
    logic                      s2_eof_reg;
    logic [PW-1:0]             s2_rm1_reg;
    logic [PW-1:0]             s2_cm1_reg;
    colsum_t                   s2_full_reg [3];
    colsum_t                   s2_low_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_mask_reg <= s1_mask_reg;
            s2_row3_reg <= s1_row3_reg;
            s2_col3_reg <= s1_col3_reg;
            s2_eof_reg  <= s1_eof_reg;
            s2_rm1_reg  <= s1_rm1_reg;
            s2_cm1_reg  <= s1_cm1_reg;
            s2_full_reg <= colsum_full;
            s2_low_reg  <= colsum_low;
        end
    end

    // Per-lane neighbourhood sum and divisor. Lanes in the last row drop the
    // top window row; lanes in the last column drop the left window column.
    logic                             lane_rows3 [bfm_pkg::LANES];
    logic                             lane_cols3 [bfm_pkg::LANES];
    logic [bfm_pkg::SUM_W-1:0]        lane_sum   [bfm_pkg::LANES];
    bfm_pkg::div_t                    lane_div   [bfm_pkg::LANES];
    logic [bfm_pkg::OUT_POS_W-1:0]    lane_row   [bfm_pkg::LANES];
    logic [bfm_pkg::OUT_POS_W-1:0]    lane_col   [bfm_pkg::LANES];
    colsum_t                          lane_colv  [3];

    always_comb
    begin
        lane_rows3[bfm_pkg::LANE_A] = s2_row3_reg;
        lane_cols3[bfm_pkg::LANE_A] = s2_col3_reg;
        lane_rows3[bfm_pkg::LANE_B] = s2_row3_reg;
        lane_cols3[bfm_pkg::LANE_B] = 1'b0;
        lane_rows3[bfm_pkg::LANE_C] = 1'b0;
        lane_cols3[bfm_pkg::LANE_C] = s2_col3_reg;
        lane_rows3[bfm_pkg::LANE_D] = 1'b0;
        lane_cols3[bfm_pkg::LANE_D] = 1'b0;

        lane_row[bfm_pkg::LANE_A] = to_out_pos(s2_rm1_reg);
        lane_col[bfm_pkg::LANE_A] = to_out_pos(s2_cm1_reg);
        lane_row[bfm_pkg::LANE_B] = to_out_pos(s2_rm1_reg);
        lane_col[bfm_pkg::LANE_B] = to_out_pos(side_m1);
        lane_row[bfm_pkg::LANE_C] = to_out_pos(side_m1);
        lane_col[bfm_pkg::LANE_C] = to_out_pos(s2_cm1_reg);
        lane_row[bfm_pkg::LANE_D] = to_out_pos(side_m1);
        lane_col[bfm_pkg::LANE_D] = to_out_pos(side_m1);

        for (int j = 0; j < 3; j++)
        begin
            lane_colv[j] = '0;
        end
        for (int i = 0; i < bfm_pkg::LANES; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lane_colv[j] = lane_rows3[i] ? s2_full_reg[j] : s2_low_reg[j];
            end
            lane_sum[i] = (lane_cols3[i] ? bfm_pkg::SUM_W'(lane_colv[0]) : '0)
                        + bfm_pkg::SUM_W'(lane_colv[1]) + bfm_pkg::SUM_W'(lane_colv[2]);
            if (lane_rows3[i] && lane_cols3[i])
            begin
                lane_div[i] = bfm_pkg::DIV_BY_9;
            end
            else if (lane_rows3[i] || lane_cols3[i])
            begin
                lane_div[i] = bfm_pkg::DIV_BY_6;
            end
            else
            begin
                lane_div[i] = bfm_pkg::DIV_BY_4;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: division by reciprocal multiply (a shift for four neighbours), then into the result queue.
    // ------------------------------------------------------------------
    logic                          s3_valid_reg;
    logic [bfm_pkg::LANES-1:0]     s3_mask_reg;
    logic                          s3_eof_reg;
    logic [bfm_pkg::SUM_W-1:0]     s3_sum_reg [bfm_pkg::LANES];
    bfm_pkg::div_t                 s3_div_reg [bfm_pkg::LANES];
    logic [bfm_pkg::OUT_POS_W-1:0] s3_row_reg [bfm_pkg::LANES];
    logic [bfm_pkg::OUT_POS_W-1:0] s3_col_reg [bfm_pkg::LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_mask_reg <= s2_mask_reg;
            s3_eof_reg  <= s2_eof_reg;
            s3_sum_reg  <= lane_sum;
            s3_div_reg  <= lane_div;
            s3_row_reg  <= lane_row;
            s3_col_reg  <= lane_col;
        end
    end

    logic [bfm_pkg::LANES-1:0]  push_mask;
    bfm_pkg::result_t           push_data [bfm_pkg::LANES];
    logic [bfm_pkg::SUM_W-1:0]  mul_a     [bfm_pkg::LANES];
    logic [bfm_pkg::RECIP_W-1:0] mul_k    [bfm_pkg::LANES];
    logic [PRODUCT_W-1:0]       product   [bfm_pkg::LANES];
    logic [bfm_pkg::SUM_W-1:0]  quarter   [bfm_pkg::LANES];
    logic                       later_set;

    always_comb
    begin
        push_mask = s3_valid_reg ? s3_mask_reg : '0;
        s3_count  = '0;
        later_set = 1'b0;
        for (int i = 0; i < bfm_pkg::LANES; i++)
        begin
            s3_count = s3_count + bfm_pkg::FIFO_CW'(push_mask[i]);
        end
        for (int i = bfm_pkg::LANES - 1; i >= 0; i--)
        begin
            unique case (s3_div_reg[i])
                bfm_pkg::DIV_BY_6:
                begin
                    mul_a[i] = s3_sum_reg[i] >> 1;
                    mul_k[i] = bfm_pkg::RECIP_3;
                end
                bfm_pkg::DIV_BY_9:
                begin
                    mul_a[i] = s3_sum_reg[i];
                    mul_k[i] = bfm_pkg::RECIP_9;
                end
                default:
                begin
                    mul_a[i] = '0;
                    mul_k[i] = '0;
                end
            endcase
            product[i] = PRODUCT_W'(mul_a[i]) * PRODUCT_W'(mul_k[i]);
            quarter[i] = s3_sum_reg[i] >> 2;
            if (s3_div_reg[i] == bfm_pkg::DIV_BY_4)
            begin
                push_data[i].smoothed = quarter[i][bfm_pkg::PIXEL_W-1:0];
            end
            else
            begin
                push_data[i].smoothed =
                    product[i][bfm_pkg::RECIP_SHIFT +: bfm_pkg::PIXEL_W];
            end
            push_data[i].row    = s3_row_reg[i];
            push_data[i].column = s3_col_reg[i];
            push_data[i].eof    = s3_eof_reg;
            // The last valid lane closes the results of this pixel.
            push_data[i].last   = s3_mask_reg[i] && !later_set;
            later_set           = later_set || s3_mask_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // Result queue and output port.
    // ------------------------------------------------------------------
    bfm_pkg::result_t head;
    logic             pop;

    assign out_valid = (fifo_count != '0);
    assign pop       = out_valid && !out_stall;

    bfm_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_mask (push_mask),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .count     (fifo_count)
    );

    assign smoothed     = head.smoothed;
    assign out_row      = head.row;
    assign out_column   = head.column;
    assign last         = head.last;
    assign end_of_frame = head.eof;

endmodule

// ----- hw/rtl/bfm_line_store.sv -----
module bfm_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Synchronous write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bfm_result_fifo.sv -----
module bfm_result_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bfm_pkg::LANES-1:0]        push_mask,
    input  bfm_pkg::result_t                 push_data [bfm_pkg::LANES],
    input  logic                             pop,
    output bfm_pkg::result_t                 head,
    output logic [bfm_pkg::FIFO_CW-1:0]      count
);

    bfm_pkg::result_t                 mem [bfm_pkg::FIFO_DEPTH];
    logic [bfm_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [bfm_pkg::FIFO_AW-1:0]      wr_ptr_next;
    logic [bfm_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [bfm_pkg::FIFO_AW-1:0]      rd_ptr_next;
    logic [bfm_pkg::FIFO_CW-1:0]      count_reg;
    logic [bfm_pkg::FIFO_CW-1:0]      count_next;
    logic [bfm_pkg::FIFO_AW-1:0]      slot [bfm_pkg::LANES];
    logic [bfm_pkg::FIFO_AW-1:0]      n_push;

    // Valid lanes are packed into consecutive slots starting at the write pointer.
    always_comb
    begin
        n_push = '0;
        for (int i = 0; i < bfm_pkg::LANES; i++)
        begin
            slot[i] = wr_ptr_reg + n_push;
            n_push  = n_push + bfm_pkg::FIFO_AW'(push_mask[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < bfm_pkg::LANES; i++)
        begin
            if (push_mask[i])
            begin
                mem[slot[i]] <= push_data[i];
            end
        end
    end

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + bfm_pkg::FIFO_AW'(pop);
        count_next  = count_reg + bfm_pkg::FIFO_CW'(n_push) - bfm_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int LINE_MAX      = 1024;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 16;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_BUDGET = 342;

    // Kinds of words waiting to be sent to the block.
    typedef enum logic {
        WORD_PIXEL,
        WORD_SIZE
    } word_kind_t;

    typedef struct {
        word_kind_t                 kind;
        logic [bfm_pkg::SIZE_W-1:0] value;
        int                         gap;
        bit                         hold;
        bit                         calm;
    } stim_word_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bfm_pkg::SIZE_W-1:0]    image_size = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [bfm_pkg::PIXEL_W-1:0]   pixel = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [bfm_pkg::PIXEL_W-1:0]   smoothed;
    logic [bfm_pkg::OUT_POS_W-1:0] out_row;
    logic [bfm_pkg::OUT_POS_W-1:0] out_column;
    logic                          last;
    logic                          end_of_frame;

    box_filter_3x3_edge_mean_unit #(
        .MAX_SIZE(LINE_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .image_size(image_size),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel(pixel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .smoothed(smoothed),
        .out_row(out_row),
        .out_column(out_column),
        .last(last),
        .end_of_frame(end_of_frame)
    );

    // Words still to be sent, and results the filter model says must come out.
    stim_word_t         stimulus[$];
    bfm_pkg::result_t   expected_results[$];
    int         pending_results = 0;
    int         failures = 0;
    int         cycles = 0;
    bit         calm_phase = 1'b0;
    bit         fill_calm = 1'b0;

    // Filter model state: two previous rows, the 3x3 window and the scan position.
    logic [bfm_pkg::PIXEL_W-1:0] line_far [LINE_MAX];
    logic [bfm_pkg::PIXEL_W-1:0] line_near [LINE_MAX];
    logic [bfm_pkg::PIXEL_W-1:0] win [3][3];
    int                          cur_row = 0;
    int                          cur_col = 0;
    logic [bfm_pkg::SIZE_W-1:0]  size_reg = 11'd8;

    // Driver and monitor bookkeeping.
    int settle = 0;
    int gap_left = 0;
    bit armed = 1'b0;
    int stall_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int side_of(input logic [bfm_pkg::SIZE_W-1:0] size);
        if (size < 2)
            return 2;
        if (size > LINE_MAX)
            return LINE_MAX;
        return int'(size);
    endfunction

    // Truncated mean of the window cells that lie inside the image and around (orow, ocol).
    // Window cell [k][j] holds image pixel (r-2+k, c-2+j).
    function automatic logic [bfm_pkg::PIXEL_W-1:0] window_mean(input int r, input int c,
                                                                input int s, input int orow,
                                                                input int ocol);
        int sum;
        int cnt;
        int ar;
        int ac;
        sum = 0;
        cnt = 0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ar = r - 2 + k;
                ac = c - 2 + j;
                if (ar >= 0 && ar < s && ar >= orow - 1 && ar <= orow + 1 &&
                    ac >= 0 && ac < s && ac >= ocol - 1 && ac <= ocol + 1)
                begin
                    sum += win[k][j];
                    cnt++;
                end
            end
        end
        if (cnt == 0)
            return '0;
        return bfm_pkg::PIXEL_W'(sum / cnt);
    endfunction

    function automatic bfm_pkg::result_t smoothed_word(input int r, input int c, input int s,
                                                       input int orow, input int ocol,
                                                       input bit eof);
        bfm_pkg::result_t w;
        w.smoothed = window_mean(r, c, s, orow, ocol);
        w.row      = orow[bfm_pkg::OUT_POS_W-1:0];
        w.column   = ocol[bfm_pkg::OUT_POS_W-1:0];
        w.last     = 1'b0;
        w.eof      = eof;
        return w;
    endfunction

    // Advance the filter model by one pixel and queue the results it releases.
    task automatic filter_pixel(input logic [bfm_pkg::PIXEL_W-1:0] p);
        int         s;
        int         r;
        int         c;
        int         n;
        bit         last_row;
        bit         last_col;
        bit         eof;
        logic [bfm_pkg::PIXEL_W-1:0] far_v;
        logic [bfm_pkg::PIXEL_W-1:0] near_v;
        bfm_pkg::result_t            batch [bfm_pkg::LANES];
        s = side_of(size_reg);
        if (cur_row >= s)
            cur_row = 0;
        if (cur_col >= s)
            cur_col = 0;
        r = cur_row;
        c = cur_col;
        far_v = line_far[c];
        near_v = line_near[c];
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = far_v;
        win[1][2] = near_v;
        win[2][2] = p;
        line_far[c] = near_v;
        line_near[c] = p;
        last_row = (r == s - 1);
        last_col = (c == s - 1);
        eof = last_row && last_col;
        n = 0;
        if (r >= 1 && c >= 1)
        begin
            batch[n] = smoothed_word(r, c, s, r - 1, c - 1, eof);
            n++;
        end
        if (r >= 1 && last_col)
        begin
            batch[n] = smoothed_word(r, c, s, r - 1, s - 1, eof);
            n++;
        end
        if (last_row && c >= 1)
        begin
            batch[n] = smoothed_word(r, c, s, s - 1, c - 1, eof);
            n++;
        end
        if (eof)
        begin
            batch[n] = smoothed_word(r, c, s, s - 1, s - 1, eof);
            n++;
        end
        if (n > 0)
            batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(batch[i]);
        if (last_col)
        begin
            cur_col = 0;
            cur_row = last_row ? 0 : r + 1;
        end
        else
        begin
            cur_col = c + 1;
        end
    endtask

    task automatic add_size(input logic [bfm_pkg::SIZE_W-1:0] value, input bit calm);
        stim_word_t w;
        fill_calm = calm;
        w.kind = WORD_SIZE;
        w.value = value;
        w.gap = 0;
        w.hold = 1'b0;
        w.calm = calm;
        stimulus.push_back(w);
    endtask

    task automatic add_pixel(input logic [bfm_pkg::PIXEL_W-1:0] value, input bit hold);
        stim_word_t w;
        w.kind = WORD_PIXEL;
        w.value = {3'b000, value};
        w.gap = fill_calm ? 0 : $urandom_range(0, 8);
        w.hold = hold;
        w.calm = fill_calm;
        stimulus.push_back(w);
    endtask

    function automatic logic [bfm_pkg::PIXEL_W-1:0] random_pixel();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return bfm_pkg::PIXEL_W'($urandom_range(0, 255));
    endfunction

    // Driver: sends queued words, honoring gaps, drain points and the idle rule for size writes.
    always @(posedge clk)
    begin
        logic nxt_in;
        logic nxt_cfg;
        if (rst_n)
        begin
            nxt_in = in_valid && in_stall;
            nxt_cfg = cfg_valid && !cfg_ready;
            if ((in_valid && !in_stall) || (cfg_valid && cfg_ready))
                settle = 0;
            else if (settle < 1000)
                settle++;
            if (!nxt_in && !nxt_cfg && stimulus.size() > 0)
            begin
                if (!armed)
                begin
                    gap_left = stimulus[0].gap;
                    armed = 1'b1;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (stimulus[0].kind == WORD_SIZE)
                begin
                    if (pending_results == 0 && settle >= SETTLE_CYCLES)
                    begin
                        image_size <= stimulus[0].value;
                        calm_phase <= stimulus[0].calm;
                        nxt_cfg = 1'b1;
                        armed = 1'b0;
                        void'(stimulus.pop_front());
                    end
                end
                else if (!stimulus[0].hold || (pending_results == 0 && settle >= 2))
                begin
                    pixel <= stimulus[0].value[bfm_pkg::PIXEL_W-1:0];
                    nxt_in = 1'b1;
                    armed = 1'b0;
                    void'(stimulus.pop_front());
                end
            end
            in_valid <= nxt_in;
            cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: checks each result word, follows accepted writes and pixels, drives out_stall.
    always @(posedge clk)
    begin
        bfm_pkg::result_t got;
        bfm_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.smoothed = smoothed;
                got.row      = out_row;
                got.column   = out_column;
                got.last     = last;
                got.eof      = end_of_frame;
                if (expected_results.size() == 0)
                begin
                    if (failures < REPORT_MAX)
                        $display("unexpected result word: smoothed %0d row %0d col %0d",
                                 got.smoothed, got.row, got.column);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (failures < REPORT_MAX)
                            $display("result mismatch: expected %0d (%0d,%0d) last %0b eof %0b, got %0d (%0d,%0d) last %0b eof %0b",
                                     want.smoothed, want.row, want.column, want.last, want.eof,
                                     got.smoothed, got.row, got.column, got.last, got.eof);
                        failures++;
                    end
                end
                stall_left = calm_phase ? 0 : $urandom_range(0, 8);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);

            // A size write restarts the frame; line stores and window are kept.
            if (cfg_valid && cfg_ready)
            begin
                size_reg = image_size;
                cur_row = 0;
                cur_col = 0;
            end
            if (in_valid && !in_stall)
                filter_pixel(pixel);
            pending_results <= expected_results.size();
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[box_filter_3x3_edge_mean_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int random_items;
        int s;
        int count;
        int pick;
        logic [bfm_pkg::SIZE_W-1:0] size;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            line_far[i] = '0;
            line_near[i] = '0;
        end
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                win[k][j] = '0;

        // One full frame at the size the block comes out of reset with.
        fill_calm = 1'b0;
        for (int i = 0; i < 64; i++)
            add_pixel(random_pixel(), 1'b0);
        random_items = 64;

        // Directed: smallest frame twice with all four results at its last pixel, a 3x3
        // frame of alternating extremes, then sizes below the minimum and a restart mid-frame.
        add_size(11'd2, 1'b0);
        add_pixel(8'hFF, 1'b0);
        add_pixel(8'hFF, 1'b0);
        add_pixel(8'hFF, 1'b0);
        add_pixel(8'hFE, 1'b0);
        add_pixel(8'h00, 1'b0);
        add_pixel(8'h00, 1'b1);
        add_pixel(8'h01, 1'b0);
        add_pixel(8'h00, 1'b0);
        add_size(11'd3, 1'b1);
        for (int i = 0; i < 9; i++)
            add_pixel((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0);
        add_size(11'd0, 1'b0);
        add_pixel(8'h80, 1'b0);
        add_pixel(8'h7F, 1'b0);
        add_pixel(8'h55, 1'b0);
        add_size(11'd1, 1'b0);
        add_pixel(8'hAA, 1'b0);
        add_pixel(8'h00, 1'b1);
        add_pixel(8'hFF, 1'b0);
        add_pixel(8'h0F, 1'b0);
        random_items += 24;

        // Random phases: mostly whole frames, some cut short by the next size write.
        while (random_items < RANDOM_BUDGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                size = bfm_pkg::SIZE_W'($urandom_range(0, 1));
            else if (pick == 1)
                size = bfm_pkg::SIZE_W'($urandom_range(LINE_MAX + 1, 2047));
            else
                size = bfm_pkg::SIZE_W'($urandom_range(2, 9));
            s = side_of(size);
            if (s == LINE_MAX)
                count = $urandom_range(1, 6);
            else if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, s * s);
            else
                count = s * s * $urandom_range(1, 2);
            if (count > RANDOM_BUDGET - random_items)
                count = RANDOM_BUDGET - random_items;
            add_size(size, $urandom_range(0, 3) == 0);
            for (int i = 0; i < count; i++)
                add_pixel(random_pixel(), $urandom_range(0, 40) == 0);
            random_items += count;
        end

        // Largest image and all size bits set, each cut short before any result; then 4x4.
        add_size(11'd1024, 1'b1);
        for (int i = 0; i < 8; i++)
            add_pixel(random_pixel(), 1'b0);
        add_size(11'd2047, 1'b0);
        for (int i = 0; i < 4; i++)
            add_pixel(random_pixel(), 1'b0);
        add_size(11'd4, 1'b0);
        for (int i = 0; i < 16; i++)
            add_pixel(random_pixel(), 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (stimulus.size() != 0 || in_valid || cfg_valid || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);

        if (failures == 0 && expected_results.size() == 0)
        begin
            $display("[box_filter_3x3_edge_mean_unit] OK");
        end
        else
        begin
            if (expected_results.size() != 0)
                $display("%0d expected result words never arrived", expected_results.size());
            $display("[box_filter_3x3_edge_mean_unit] ERROR");
        end
        $finish;
    end

endmodule
